[src/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define LSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define LSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lsp_pkg.sv]
// Types and constants for the line sensor PD motor mixer.
`default_nettype none
package lsp_pkg;

   localparam int SENSOR_W    = 7;
   localparam int REQ_TDATA_W = 8;
   localparam int DUTY_W      = 16;
   localparam int PERR_W      = 14;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CNT_W       = 3;
   localparam int MAG_W       = 6;

   // sensor count at which the outer weight set (x6) applies
   localparam logic [CNT_W-1:0] OUTER_MIN_COUNT = 3'd4;
   localparam int CENTER_SENSOR = 3;

   localparam logic [CSR_DATA_W-1:0] KP_RESET   = 16'd6000;
   localparam logic [CSR_DATA_W-1:0] KD_RESET   = 16'd0;
   localparam logic [CSR_DATA_W-1:0] BASE_RESET = 16'd10000;
   localparam logic [CSR_DATA_W-1:0] MAX_RESET  = 16'd20000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_KP   = 3'd0,
      REG_KD   = 3'd1,
      REG_BASE = 3'd2,
      REG_MAX  = 3'd3
   } reg_idx_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIV   = 8'b0000_0010,
      ST_MULP  = 8'b0000_0100,
      ST_MULD  = 8'b0000_1000,
      ST_SUMD  = 8'b0001_0000,
      ST_LEFT  = 8'b0010_0000,
      ST_RIGHT = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   // decoded sensor word: active count, sign and magnitude of the weighted sum
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sense_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

[src/lsp_front.sv]
// Sensor decode: active count and weighted position sum.
`default_nettype none
module lsp_front (
   input  logic [lsp_pkg::SENSOR_W-1:0] sensor_bits,
   output lsp_pkg::sense_type           sense
);
   import lsp_pkg::*;

   always_comb begin
      logic [CNT_W-1:0] cnt;
      logic signed [3:0] sum;
      logic [3:0] sabs;
      logic [MAG_W-1:0] sext;
      cnt = '0;
      sum = '0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (sensor_bits[i]) begin
            cnt = cnt + 3'd1;
            sum = sum + 4'(i - CENTER_SENSOR);
         end
      end
      sabs = sum[3] ? 4'(-sum) : 4'(sum);
      sext = {2'b00, sabs};
      sense.count = cnt;
      sense.neg   = sum[3];
      // times six as 4x + 2x
      sense.mag   = (cnt >= OUTER_MIN_COUNT) ? (sext << 2) + (sext << 1) : sext;
   end

endmodule
`default_nettype wire

[src/lsp_div.sv]
// Restoring divider, one quotient bit per cycle, by a 3-bit count.
`default_nettype none
module lsp_div #(
   parameter int NW = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [NW-1:0]             dividend,
   input  logic [lsp_pkg::CNT_W-1:0] divisor,
   output logic [NW-1:0]             quotient,
   output lsp_pkg::div_stat_type     stat
);
   import lsp_pkg::*;

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]    work_ff, work_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [CNT_W:0] trial;
   logic           ge;

   assign trial = {rem_ff, work_ff[NW-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // quotient bits shift in where dividend bits leave
         work_in = {work_ff[NW-2:0], ge};
         rem_in  = ge ? CNT_W'(trial - {1'b0, dvs_ff}) : CNT_W'(trial);
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = work_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire

[src/line_sensor_pd_motor_mix.sv]
// Requests are handled one at a time: a new request is taken only in the idle state,
// after the bit-serial divider and the shared multiplier (two products per request)
// have finished with the previous one.
// A finished result waits in the output register while the next request runs.
// Reset is synchronous, active high: registers return to their defaults, the
// previous error and both held directions clear to zero (forward).
`default_nettype none
module line_sensor_pd_motor_mix #(
   parameter int FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lsp_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [6:0] sensor_bits
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] left_duty, [31:16] right_duty, [32] left_reverse,
   // [33] right_reverse, [47:34] position_error
   output logic [lsp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [lsp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lsp_pkg::*;

   localparam int EW = FRAC_BITS + MAG_W;     // error and quotient
   localparam int FW = EW + 1;                // error change
   localparam int PW = FW + DUTY_W + 1;       // product
   localparam int DW = PW + 1;                // drive
   localparam int SW = DW + 1;                // side value
   localparam int MW = SW - FRAC_BITS;        // side magnitude, integer part
   localparam int XW = (EW > PERR_W) ? EW : PERR_W;

   state_type state_ff, state_in;
   logic [DUTY_W-1:0] kp_ff, kp_in, kd_ff, kd_in, base_ff, base_in, max_ff, max_in;
   logic zero_ff, zero_in, neg_ff, neg_in;
   logic signed [EW-1:0] err_ff, err_in, prev_ff, prev_in;
   logic signed [FW-1:0] diff_ff, diff_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [DW-1:0] drive_ff, drive_in;
   logic [DUTY_W-1:0] lduty_ff, lduty_in, rduty_ff, rduty_in;
   logic lrev_ff, lrev_in, rrev_ff, rrev_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   sense_type        sense;
   div_stat_type     div_stat;
   logic [EW-1:0]    quot;
   logic             accept;
   logic             out_free;
   logic             err_zero;

   logic [DUTY_W-1:0]    mul_gain;
   logic signed [FW-1:0] mul_opnd;
   logic signed [PW-1:0] mul_out;

   logic signed [SW-1:0] base_ext, drive_ext, side;
   logic [SW-1:0]        side_abs;
   logic [MW-1:0]        side_mag;
   logic [DUTY_W-1:0]    side_duty;
   logic                 side_rev;
   logic signed [XW-1:0] err_wide;

   lsp_front u_front (
      .sensor_bits (req_tdata[SENSOR_W-1:0]),
      .sense       (sense)
   );

   lsp_div #(.NW(EW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({sense.mag, {FRAC_BITS{1'b0}}}),
      .divisor  (sense.count),
      .quotient (quot),
      .stat     (div_stat)
   );

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign err_zero   = (err_ff == '0);

   // shared multiplier: kp * error, then kd * error change
   assign mul_gain = (state_ff == ST_MULP) ? kp_ff : kd_ff;
   assign mul_opnd = (state_ff == ST_MULP) ? FW'(err_ff) : diff_ff;
   assign mul_out  = $signed({1'b0, mul_gain}) * mul_opnd;

   // shared side adder: base - drive on the left pass, base + drive on the right
   assign base_ext  = $signed({{(SW - DUTY_W - FRAC_BITS){1'b0}}, base_ff,
                               {FRAC_BITS{1'b0}}});
   assign drive_ext = SW'(drive_ff);
   assign side      = (state_ff == ST_LEFT) ? base_ext - drive_ext : base_ext + drive_ext;
   assign side_rev  = side[SW-1];
   assign side_abs  = side_rev ? SW'(-side) : SW'(side);
   assign side_mag  = side_abs[SW-1:FRAC_BITS];
   assign side_duty = (side_mag > {{(MW - DUTY_W){1'b0}}, max_ff}) ? max_ff
                                                                   : side_mag[DUTY_W-1:0];

   assign err_wide = XW'(err_ff);

   always_comb begin
      state_in     = state_ff;
      kp_in        = kp_ff;
      kd_in        = kd_ff;
      base_in      = base_ff;
      max_in       = max_ff;
      zero_in      = zero_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      drive_in     = drive_ff;
      lduty_in     = lduty_ff;
      rduty_in     = rduty_ff;
      lrev_in      = lrev_ff;
      rrev_in      = rrev_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_addr)
            REG_KP:   kp_in   = csr_wdata;
            REG_KD:   kd_in   = csr_wdata;
            REG_BASE: base_in = csr_wdata;
            REG_MAX:  max_in  = csr_wdata;
            default:  ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               zero_in  = (sense.count == '0);
               neg_in   = sense.neg;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               // no active sensor: error forced to zero
               if (zero_ff) begin
                  err_in = '0;
               end else begin
                  err_in = neg_ff ? -$signed(quot) : $signed(quot);
               end
               state_in = ST_MULP;
            end
         end
         ST_MULP: begin
            prod_in  = mul_out;
            diff_in  = FW'(err_ff) - FW'(prev_ff);
            prev_in  = err_ff;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            drive_in = DW'(prod_ff);
            prod_in  = mul_out;
            state_in = ST_SUMD;
         end
         ST_SUMD: begin
            drive_in = drive_ff + DW'(prod_ff);
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            if (err_zero) begin
               lduty_in = max_ff;
            end else begin
               lduty_in = side_duty;
               lrev_in  = side_rev;
            end
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            if (err_zero) begin
               rduty_in = max_ff;
            end else begin
               rduty_in = side_duty;
               rrev_in  = side_rev;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = {err_wide[PERR_W-1:0], rrev_ff, lrev_ff, rduty_ff, lduty_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      zero_ff     <= zero_in;
      neg_ff      <= neg_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      drive_ff    <= drive_in;
      lduty_ff    <= lduty_in;
      rduty_ff    <= rduty_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         kp_ff        <= KP_RESET;
         kd_ff        <= KD_RESET;
         base_ff      <= BASE_RESET;
         max_ff       <= MAX_RESET;
         prev_ff      <= '0;
         lrev_ff      <= 1'b0;
         rrev_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kp_ff        <= kp_in;
         kd_ff        <= kd_in;
         base_ff      <= base_in;
         max_ff       <= max_in;
         prev_ff      <= prev_in;
         lrev_ff      <= lrev_in;
         rrev_ff      <= rrev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[src/lsp_checker.sv]
// Port-level assertions for the motor mixer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lsp_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [lsp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // reset leaves no result pending and the block ready once reset drops
   `LSP_ASSERT_ALWAYS(a_reset_clear, clock,
                      reset |=> (!rsp_tvalid && (req_tready || reset)),
                      "reset did not clear the block")

   // a request occupies the block; it cannot take another at once
   `LSP_ASSERT(a_busy_after_req, clock, reset,
               (req_tvalid && req_tready) |=> !req_tready,
               "request taken while busy")

   `LSP_ASSERT(a_rsp_hold, clock, reset,
               (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)),
               "stalled result changed")

endmodule

bind line_sensor_pd_motor_mix lsp_checker u_lsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

[test/tb_top.sv]
// Testbench for the line sensor PD motor mixer: directed table, then randomized phases.
`timescale 1ns / 100ps
module tb_top;
   import lsp_pkg::*;

   localparam int FRAC_BITS      = 8;
   localparam int OUTER_WEIGHT   = 6;
   localparam int LATENCY        = FRAC_BITS + 13;
   localparam int END_CYCLES     = 2 * LATENCY;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RAND_PHASES    = 9;
   localparam int PHASE_ITEMS    = 190;
   localparam int DIR_ROWS       = 33;

   // indexes past the register list; writes there must be ignored
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_FIRST = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

   // same bit layout as rsp_tdata
   typedef struct packed {
      logic [PERR_W-1:0] position_error;
      logic              right_reverse;
      logic              left_reverse;
      logic [DUTY_W-1:0] right_duty;
      logic [DUTY_W-1:0] left_duty;
   } motor_cmd_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;   // sensor word for a request row
      bit                    typed;
      motor_cmd_type         want;
   } dir_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // mirror of the mixer's settings and state
   logic [CSR_DATA_W-1:0] kp_set   = KP_RESET;
   logic [CSR_DATA_W-1:0] kd_set   = KD_RESET;
   logic [CSR_DATA_W-1:0] base_set = BASE_RESET;
   logic [CSR_DATA_W-1:0] max_set  = MAX_RESET;
   longint                prior_err = 0;
   logic                  hold_left  = 1'b0;
   logic                  hold_right = 1'b0;

   motor_cmd_type pending_cmds[$];
   int            mismatch_cnt = 0;
   int            idle_cycles  = 0;
   int            rsp_hold     = 0;
   bit            rsp_fast     = 1'b0;
   bit            tx_fast      = 1'b0;

   // want fields: perr, rrev, lrev, rduty, lduty
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{ROW_REQ, REG_KP,   16'h0000, 1'b1, '{14'h0000, 1'b0, 1'b0, 16'd20000, 16'd20000}},
      '{ROW_REQ, REG_KP,   16'h0008, 1'b1, '{14'h0000, 1'b0, 1'b0, 16'd20000, 16'd20000}},
      '{ROW_REQ, REG_KP,   16'h0001, 1'b1, '{14'h3D00, 1'b1, 1'b0, 16'd8000,  16'd20000}},
      '{ROW_REQ, REG_KP,   16'h0008, 1'b1, '{14'h0000, 1'b1, 1'b0, 16'd20000, 16'd20000}},
      '{ROW_REQ, REG_KP,   16'h0040, 1'b1, '{14'h0300, 1'b0, 1'b1, 16'd20000, 16'd8000}},
      '{ROW_REQ, REG_KP,   16'h007F, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h000F, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0078, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0007, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0070, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h007E, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h003F, 1'b0, '0},
      '{ROW_CSR, REG_KP,   16'hFFFF, 1'b0, '0},
      '{ROW_CSR, REG_KD,   16'hFFFF, 1'b0, '0},
      '{ROW_CSR, REG_BASE, 16'hFFFF, 1'b0, '0},
      '{ROW_CSR, REG_MAX,  16'hFFFF, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0001, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0040, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0001, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0078, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h000F, 1'b0, '0},
      // tiny drive around zero base: side values just either side of zero
      '{ROW_CSR, REG_KP,   16'h0001, 1'b0, '0},
      '{ROW_CSR, REG_KD,   16'h0000, 1'b0, '0},
      '{ROW_CSR, REG_BASE, 16'h0000, 1'b0, '0},
      '{ROW_CSR, REG_MAX,  16'hFFFF, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0018, 1'b1, '{14'h0080, 1'b0, 1'b1, 16'd0, 16'd0}},
      '{ROW_REQ, REG_KP,   16'h000C, 1'b0, '0},
      '{ROW_CSR, REG_MAX,  16'h0000, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0001, 1'b1, '{14'h3D00, 1'b1, 1'b0, 16'd0, 16'd0}},
      '{ROW_REQ, REG_KP,   16'h0000, 1'b1, '{14'h0000, 1'b1, 1'b0, 16'd0, 16'd0}},
      '{ROW_CSR, REG_SPARE_FIRST, 16'hFFFF, 1'b0, '0},
      '{ROW_CSR, REG_SPARE_LAST,  16'h5A5A, 1'b0, '0},
      '{ROW_REQ, REG_KP,   16'h0001, 1'b0, '0}
   };

   line_sensor_pd_motor_mix #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [6:0] sensor_bits
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] left_duty, [31:16] right_duty,
                                  // [32] left_reverse, [33] right_reverse,
                                  // [47:34] position_error
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // truncated magnitude of one side, clamped; sign goes to the held direction
   function automatic void clamp_side(input longint num, output logic [DUTY_W-1:0] duty,
                                      output logic rev);
      longint mag;
      rev = (num < 0);
      mag = (num < 0 ? -num : num) >>> FRAC_BITS;
      if (mag > longint'(max_set))
         mag = longint'(max_set);
      duty = mag[DUTY_W-1:0];
   endfunction

   function automatic motor_cmd_type mix_motor_cmd(input logic [SENSOR_W-1:0] bits);
      motor_cmd_type cmd;
      int            hits;
      longint        wsum;
      longint        mag;
      longint        err;
      longint        drive;
      longint        base;
      hits = 0;
      wsum = 0;
      err  = 0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (bits[i]) begin
            hits++;
            wsum += i - CENTER_SENSOR;
         end
      end
      if (hits != 0) begin
         if (hits >= int'(OUTER_MIN_COUNT))
            wsum = wsum * OUTER_WEIGHT;
         mag = (wsum < 0 ? -wsum : wsum) <<< FRAC_BITS;
         mag = mag / hits;
         err = (wsum < 0) ? -mag : mag;
      end
      drive = longint'(kp_set) * err + longint'(kd_set) * (err - prior_err);
      prior_err = err;
      cmd.position_error = err[PERR_W-1:0];
      if (err == 0) begin
         cmd.left_duty  = max_set;
         cmd.right_duty = max_set;
      end else begin
         base = longint'(base_set) <<< FRAC_BITS;
         clamp_side(base - drive, cmd.left_duty, hold_left);
         clamp_side(base + drive, cmd.right_duty, hold_right);
      end
      cmd.left_reverse  = hold_left;
      cmd.right_reverse = hold_right;
      return cmd;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) < 15)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int next_gap();
      if (tx_fast || $urandom_range(0, 9) < 5)
         return 0;
      return gap_len();
   endfunction

   // mostly a line seen by one to three adjacent sensors, the rest noise
   function automatic logic [SENSOR_W-1:0] pick_sensor();
      int w;
      int s;
      if ($urandom_range(0, 9) < 6) begin
         w = $urandom_range(1, 3);
         s = $urandom_range(0, SENSOR_W - w);
         return ((7'd1 << w) - 7'd1) << s;
      end
      return SENSOR_W'($urandom);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_reg();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return CSR_DATA_W'($urandom_range(0, 255));
         4, 5: return CSR_DATA_W'($urandom_range(0, 4095));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         REG_KP:   kp_set   = value;
         REG_KD:   kd_set   = value;
         REG_BASE: base_set = value;
         REG_MAX:  max_set  = value;
         default: ;
      endcase
   endtask

   // hold off the sender until every pending result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending_cmds.size() != 0);
   endtask

   task automatic send_sensor(input logic [SENSOR_W-1:0] bits, input int gap, input bit typed,
                              input motor_cmd_type want);
      motor_cmd_type pred;
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(bits);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pred = mix_motor_cmd(bits);
      pending_cmds.push_back(typed ? want : pred);
   endtask

   // result check and receiver stalls
   always @(posedge clock) begin
      motor_cmd_type got;
      motor_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_cmds.size() == 0) begin
            $error("result with no request pending: %h", rsp_tdata);
            mismatch_cnt++;
         end else begin
            want = pending_cmds.pop_front();
            if (got.left_duty !== want.left_duty) begin
               $error("left_duty expected %0d got %0d", want.left_duty, got.left_duty);
               mismatch_cnt++;
            end
            if (got.right_duty !== want.right_duty) begin
               $error("right_duty expected %0d got %0d", want.right_duty, got.right_duty);
               mismatch_cnt++;
            end
            if (got.left_reverse !== want.left_reverse) begin
               $error("left_reverse expected %0b got %0b", want.left_reverse,
                      got.left_reverse);
               mismatch_cnt++;
            end
            if (got.right_reverse !== want.right_reverse) begin
               $error("right_reverse expected %0b got %0b", want.right_reverse,
                      got.right_reverse);
               mismatch_cnt++;
            end
            if (got.position_error !== want.position_error) begin
               $error("position_error expected %h got %h", want.position_error,
                      got.position_error);
               mismatch_cnt++;
            end
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_fast && $urandom_range(0, 3) == 0)
            rsp_hold = gap_len();
      end
      if ($urandom_range(0, 299) == 0)
         rsp_fast = !rsp_fast;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            if (i == 0 || dir_tab[i-1].kind != ROW_CSR)
               wait_drained();
            write_reg(dir_tab[i].addr, dir_tab[i].value);
         end else begin
            send_sensor(dir_tab[i].value[SENSOR_W-1:0], next_gap(), dir_tab[i].typed,
                        dir_tab[i].want);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_drained();
         if (ph == 0) begin
            write_reg(REG_KP, KP_RESET);
            write_reg(REG_KD, KD_RESET);
            write_reg(REG_BASE, BASE_RESET);
            write_reg(REG_MAX, MAX_RESET);
         end else if (ph == 1) begin
            write_reg(REG_KP, '1);
            write_reg(REG_KD, '1);
            write_reg(REG_BASE, '1);
            write_reg(REG_MAX, '1);
         end else begin
            write_reg(REG_KP, pick_reg());
            write_reg(REG_KD, pick_reg());
            write_reg(REG_BASE, pick_reg());
            write_reg(REG_MAX, pick_reg());
         end
         write_reg(CSR_ADDR_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                   CSR_DATA_W'($urandom));
         tx_fast = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 199) == 0) begin
               wait_drained();
               send_sensor(pick_sensor(), 0, 1'b0, '0);
            end else begin
               send_sensor(pick_sensor(), next_gap(), 1'b0, '0);
            end
         end
      end

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

[line_sensor_pd_motor_mix.f]
+incdir+src
src/lsp_pkg.sv
src/lsp_front.sv
src/lsp_div.sv
src/line_sensor_pd_motor_mix.sv
src/lsp_checker.sv
test/tb_top.sv
